@@ design/bipolar_zero_substitution_encoder_core_assert.svh @@
// Assertion macros shared by the encoder RTL.
`ifndef BIPOLAR_ZERO_SUBSTITUTION_ENCODER_CORE_ASSERT_SVH
`define BIPOLAR_ZERO_SUBSTITUTION_ENCODER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define BZS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bzs: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BZS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bzs: next-cycle check failed");

`endif

@@ design/bzs_pkg.sv @@
package bzs_pkg;

    typedef logic signed [1:0] t_sym;
    typedef logic [1:0]        t_mode;

    localparam t_sym SYM_ZERO = 2'sb00;
    localparam t_sym SYM_POS  = 2'sb01;
    localparam t_sym SYM_NEG  = 2'sb11;

    localparam t_mode MODE_AMI  = 2'd0;
    localparam t_mode MODE_B8ZS = 2'd1;
    localparam t_mode MODE_HDB3 = 2'd2;

    localparam int DELAY_DEPTH = 8;
    localparam logic [2:0] RUN_MAX  = 3'd7;   // B8ZS fires on the eighth zero
    localparam logic [2:0] HDB3_RUN = 3'd3;   // HDB3 fires on the fourth zero
    localparam logic [2:0] FILL_MAX = 3'd7;

    function automatic t_sym level(input logic pos);
        return pos ? SYM_POS : SYM_NEG;
    endfunction

endpackage

@@ design/bipolar_zero_substitution_encoder_core.sv @@
// Each accepted data word has its result word in the output register in the following cycle.
// Line delay: each symbol belongs to the data bit given seven words earlier.
// Throughput: one word per cycle while i_stall is low; the single-pass encode logic and output register set this.
// Reset: synchronous, active low; delay line cleared, first mark positive, mode AMI.
// symbol_valid stays low for the first seven words while the delay line fills.
`include "bipolar_zero_substitution_encoder_core_assert.svh"

module bipolar_zero_substitution_encoder_core
    import bzs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // data in
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_data_bit,
    // symbols out
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [1:0] o_line_symbol,
    output logic        o_symbol_valid,
    // mode register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_code_mode
);

    // coder state
    t_sym       r_pend [DELAY_DEPTH];
    t_sym       n_pend [DELAY_DEPTH];
    logic       r_last_pos,  n_last_pos;
    logic [2:0] r_zero_run,  n_zero_run;
    logic       r_parity,    n_parity;
    logic [2:0] r_fill;
    t_mode      r_code_mode;

    // output register
    logic       r_out_valid;
    t_sym       r_out_sym;
    logic       r_out_sym_valid;

    logic       in_acc;
    logic       fill_done;
    t_sym       mark_sym;
    t_sym       hdb3_b;

    // Output register frees itself when its word is taken, so a new word
    // can enter on the same edge: full rate with the sink ready.
    assign o_stall     = r_out_valid && i_stall;
    assign in_acc      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;   // the user must write the mode only while idle; the block itself does not enforce this

    assign fill_done = (r_fill == FILL_MAX);
    assign mark_sym  = level(!r_last_pos);
    assign hdb3_b    = level(!r_last_pos);

    // Single pass: shift the line, enter the new symbol, then rewrite the
    // zero run in place when a substitution fires.
    always_comb begin
        for (int k = DELAY_DEPTH - 1; k > 0; k--) begin
            n_pend[k] = r_pend[k-1];
        end
        n_pend[0]  = SYM_ZERO;
        n_last_pos = r_last_pos;
        n_zero_run = r_zero_run;
        n_parity   = r_parity;

        if (i_data_bit) begin
            // mark: alternate polarity
            n_last_pos = !r_last_pos;
            n_pend[0]  = mark_sym;
            n_parity   = !r_parity;
            n_zero_run = '0;
        end else begin
            case (r_code_mode)
                MODE_B8ZS: begin
                    if (r_zero_run == RUN_MAX) begin
                        // 000VB0VB, polarity unchanged afterwards
                        n_pend[7] = SYM_ZERO;
                        n_pend[6] = SYM_ZERO;
                        n_pend[5] = SYM_ZERO;
                        n_pend[4] = level(r_last_pos);
                        n_pend[3] = level(!r_last_pos);
                        n_pend[2] = SYM_ZERO;
                        n_pend[1] = level(!r_last_pos);
                        n_pend[0] = level(r_last_pos);
                        n_zero_run = '0;
                    end else begin
                        n_zero_run = r_zero_run + 3'd1;
                    end
                end
                MODE_HDB3: begin
                    if (r_zero_run >= HDB3_RUN) begin
                        if (r_parity) begin
                            // 000V, V follows the last pulse
                            n_pend[3] = SYM_ZERO;
                            n_pend[0] = level(r_last_pos);
                        end else begin
                            // B00V, B opposite the last pulse, V equals B
                            n_last_pos = !r_last_pos;
                            n_pend[3]  = hdb3_b;
                            n_pend[0]  = hdb3_b;
                        end
                        n_pend[2]  = SYM_ZERO;
                        n_pend[1]  = SYM_ZERO;
                        n_parity   = 1'b0;
                        n_zero_run = '0;
                    end else begin
                        n_zero_run = r_zero_run + 3'd1;
                    end
                end
                default: begin
                    // AMI and the unused code: count only, saturating
                    if (r_zero_run != RUN_MAX) begin
                        n_zero_run = r_zero_run + 3'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DELAY_DEPTH; k++) begin
                r_pend[k] <= SYM_ZERO;
            end
            r_last_pos  <= 1'b0;
            r_zero_run  <= '0;
            r_parity    <= 1'b0;
            r_fill      <= '0;
            r_code_mode <= MODE_AMI;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_code_mode <= i_code_mode;
            end
            if (in_acc) begin
                for (int k = 0; k < DELAY_DEPTH; k++) begin
                    r_pend[k] <= n_pend[k];
                end
                r_last_pos <= n_last_pos;
                r_zero_run <= n_zero_run;
                r_parity   <= n_parity;
                if (!fill_done) begin
                    r_fill <= r_fill + 3'd1;
                end
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload of the output register, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_sym       <= fill_done ? n_pend[DELAY_DEPTH-1] : SYM_ZERO;
            r_out_sym_valid <= fill_done;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_line_symbol  = r_out_sym;
    assign o_symbol_valid = r_out_sym_valid;

    `BZS_ASSERT_NOW(a_fill_zero, i_clk, i_rst_n, o_valid && !o_symbol_valid, o_line_symbol == SYM_ZERO)
    `BZS_ASSERT_NOW(a_sym_legal, i_clk, i_rst_n, o_valid, o_line_symbol != 2'sb10)
    `BZS_ASSERT_NEXT(a_mark_clears_run, i_clk, i_rst_n, in_acc && i_data_bit, r_zero_run == 3'd0)
    `BZS_ASSERT_NEXT(a_fill_steps, i_clk, i_rst_n, in_acc && !fill_done, r_fill == $past(r_fill) + 3'd1)
    `BZS_ASSERT_NEXT(a_accept_loads, i_clk, i_rst_n, in_acc, o_valid)

endmodule
